@@ rtl/led_zone_pattern_renderer_top_defines.svh @@
// ---------------------------------------------------------------------------
// LED zone pattern renderer assertion macros
// Property wrappers used by the top-level file, which carries the assertions.
// ---------------------------------------------------------------------------
`ifndef LED_ZONE_PATTERN_RENDERER_TOP_DEFINES_SVH
`define LED_ZONE_PATTERN_RENDERER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LZPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LZPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lzpr_pkg.sv @@
// ---------------------------------------------------------------------------
// lzpr_pkg
// Shared types, constants and color helpers of the LED zone pattern renderer.
// ---------------------------------------------------------------------------
package lzpr_pkg;

	// Fixed field widths
	localparam int TIME_W      = 32;
	localparam int PHASE_W     = 10;
	localparam int LVL_W       = 3;
	localparam int MS_W        = 16;
	localparam int ZPIX_W      = 7;
	localparam int ZOFF_W      = 6;
	localparam int IDX_W       = 7;
	localparam int COL_W       = 8;
	localparam int BK_W        = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 32;

	// Shared divider widths
	localparam int DIVD_W = 32;
	localparam int DIVR_W = 17;
	localparam int DIVC_W = $clog2(DIVD_W + 1);

	// Algorithm constants
	localparam int PHASE_STEPS    = 768;
	localparam int LEVELS         = 8;
	localparam int MAX_PIXELS_DEF = 64;
	localparam int STEP_W         = 9;
	localparam int STEP_NUM       = PHASE_STEPS / 3;

	typedef enum logic [1:0] {
		MODE_DARK    = 2'd0,
		MODE_TEST    = 2'd1,
		MODE_CONST   = 2'd2,
		MODE_RAINBOW = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_MODE = 3'd0,
		CFG_BASE_PHASE   = 3'd1,
		CFG_LEVEL        = 3'd2,
		CFG_DIMMED_LEVEL = 3'd3,
		CFG_RAINBOW_MS   = 3'd4,
		CFG_TEST_STEP_MS = 3'd5,
		CFG_ZONE_PIXELS  = 3'd6,
		CFG_ZONE_OFFSET  = 3'd7
	} cfg_idx_t;

	// Divider jobs, one per division of a frame setup
	typedef enum logic [2:0] {
		OP_TEST_STEP,
		OP_TEST_MOD,
		OP_RB_MOD,
		OP_RB_PHASE,
		OP_RB_STEP
	} div_op_t;

	typedef struct packed {
		mode_t                 pattern_mode;
		logic [PHASE_W-1:0]    base_phase;
		logic [LVL_W-1:0]      level;
		logic [LVL_W-1:0]      dimmed_level;
		logic [MS_W-1:0]       rainbow_period_ms;
		logic [MS_W-1:0]       test_step_ms;
		logic [ZPIX_W-1:0]     zone_pixels;
		logic [ZOFF_W-1:0]     zone_offset;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    latch_in;
		logic    div_start;
		div_op_t div_op;
		logic    cap_test;
		logic    cap_phase;
		logic    cap_step;
		logic    init_pix;
		logic    pix_raw;
		logic    pix_emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic n_zero;
		logic div_done;
		logic last_pix;
		logic out_free;
	} sts_t;

	// Triangular wheel channel: rise, fall, then off
	function automatic logic [COL_W-1:0] wheel_ch(input logic [PHASE_W-1:0] p);
		logic [COL_W-1:0] c;
		if (p <= PHASE_W'(255))
			c = p[COL_W-1:0];
		else if (p <= PHASE_W'(511))
			c = COL_W'(9'd511 - p[8:0]);
		else
			c = '0;
		return c;
	endfunction

	// Reduce a value below twice the wheel length
	function automatic logic [PHASE_W-1:0] mod_wheel(input logic [PHASE_W:0] v);
		logic [PHASE_W:0] r;
		r = (v >= (PHASE_W + 1)'(PHASE_STEPS)) ? v - (PHASE_W + 1)'(PHASE_STEPS) : v;
		return r[PHASE_W-1:0];
	endfunction

	// c * (2^k - 1) / 255 with a shift-subtract and an exact reciprocal
	function automatic logic [COL_W-1:0] scale_ch(input logic [COL_W-1:0] c,
		input logic [BK_W-1:0] k);
		logic [15:0] x;
		logic [16:0] y;
		x = (16'(c) << k) - 16'(c);
		y = 17'(x) + 17'(x[15:8]) + 17'd1;
		return y[15:8];
	endfunction

endpackage

@@ rtl/led_zone_pattern_renderer_top.sv @@
// ---------------------------------------------------------------------------
// led_zone_pattern_renderer_top
// Renders one zone of LED colors per frame tick: dark, test, constant or
// rainbow pattern from a triangular color wheel, scaled by brightness.
// ---------------------------------------------------------------------------
// Channel   Dir  Request                         Handshake
// s_axis    in   frame tick: time_ms, dim_on     tvalid/tready
// m_axis    out  pixel: index, red, green, blue  tvalid/tready, tlast on last
// cfg       in   register write                  cfg_we, no wait
//
// One frame at a time. Setup runs on a shared one-bit-per-cycle divider:
// test takes two divisions, rainbow three, dark and constant none. Each
// pixel then passes a raw color state and an emit state, which waits while
// the output is stalled. The last pixel may wait in the output register
// while the next tick is accepted. A zone of zero pixels is accepted and
// yields nothing. Reset loads the register defaults.
// ---------------------------------------------------------------------------
`include "led_zone_pattern_renderer_top_defines.svh"

module led_zone_pattern_renderer_top #(
	parameter int MAX_PIXELS = lzpr_pkg::MAX_PIXELS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [31:0] time_ms, [32] dim_on
	input  logic [lzpr_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [6:0] pixel_index, [14:7] red, [22:15] green, [30:23] blue
	output logic [lzpr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic                                  m_axis_tlast,
	input  logic                                  cfg_we,
	input  logic [lzpr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lzpr_pkg::CFG_DATA_W-1:0]       cfg_data
);

	lzpr_pkg::cfg_t                   cfg;
	lzpr_pkg::cmd_t                   cmd;
	lzpr_pkg::sts_t                   sts;
	logic [lzpr_pkg::IDX_W-1:0]       pixel_index;
	logic [lzpr_pkg::COL_W-1:0]       red, green, blue;

	lzpr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lzpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.mode     (cfg.pattern_mode),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (s_axis_tready)
	);

	lzpr_dp #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.time_ms     (s_axis_tdata[lzpr_pkg::TIME_W-1:0]),
		.dim_on      (s_axis_tdata[lzpr_pkg::TIME_W]),
		.out_ready   (m_axis_tready),
		.sts         (sts),
		.out_valid   (m_axis_tvalid),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last_pixel  (m_axis_tlast)
	);

	// Pack the pixel fields, lowest field first
	assign m_axis_tdata = {1'b0, blue, green, red, pixel_index};

	// Divider never starts while waiting for a tick
	`LZPR_ASSERT_NOW(a_idle_no_div, clk, arst_n, s_axis_tready, !cmd.div_start, "divider started while idle")
	// A pixel is only loaded when the output register can take it
	`LZPR_ASSERT_NOW(a_emit_free, clk, arst_n, cmd.pix_emit, sts.out_free, "pixel overwrote a pending result")
	// The last pixel returns the sequencer to accepting ticks
	`LZPR_ASSERT_NEXT(a_last_ready, clk, arst_n, cmd.pix_emit && sts.last_pix, s_axis_tready, "not ready after last pixel")
	// A division needs many cycles, so it cannot finish right after starting
	`LZPR_ASSERT_NEXT(a_div_latency, clk, arst_n, cmd.div_start, !sts.div_done, "division finished too early")

endmodule

@@ rtl/lzpr_cfg.sv @@
// ---------------------------------------------------------------------------
// lzpr_cfg
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module lzpr_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lzpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lzpr_pkg::CFG_DATA_W-1:0]   cfg_data,
	output lzpr_pkg::cfg_t                    cfg
);

	lzpr_pkg::cfg_t cfg_q;

	// Write the addressed register, truncated to its width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_mode      <= lzpr_pkg::MODE_RAINBOW;
			cfg_q.base_phase        <= '0;
			cfg_q.level             <= lzpr_pkg::LVL_W'(7);
			cfg_q.dimmed_level      <= lzpr_pkg::LVL_W'(1);
			cfg_q.rainbow_period_ms <= lzpr_pkg::MS_W'(5000);
			cfg_q.test_step_ms      <= lzpr_pkg::MS_W'(500);
			cfg_q.zone_pixels       <= lzpr_pkg::ZPIX_W'(6);
			cfg_q.zone_offset       <= '0;
		end else if (cfg_we) begin
			case (lzpr_pkg::cfg_idx_t'(cfg_index))
				lzpr_pkg::CFG_PATTERN_MODE: begin
					cfg_q.pattern_mode <= lzpr_pkg::mode_t'(cfg_data[1:0]);
				end
				lzpr_pkg::CFG_BASE_PHASE: begin
					cfg_q.base_phase <= cfg_data[lzpr_pkg::PHASE_W-1:0];
				end
				lzpr_pkg::CFG_LEVEL: begin
					cfg_q.level <= cfg_data[lzpr_pkg::LVL_W-1:0];
				end
				lzpr_pkg::CFG_DIMMED_LEVEL: begin
					cfg_q.dimmed_level <= cfg_data[lzpr_pkg::LVL_W-1:0];
				end
				lzpr_pkg::CFG_RAINBOW_MS: begin
					cfg_q.rainbow_period_ms <= cfg_data[lzpr_pkg::MS_W-1:0];
				end
				lzpr_pkg::CFG_TEST_STEP_MS: begin
					cfg_q.test_step_ms <= cfg_data[lzpr_pkg::MS_W-1:0];
				end
				lzpr_pkg::CFG_ZONE_PIXELS: begin
					cfg_q.zone_pixels <= cfg_data[lzpr_pkg::ZPIX_W-1:0];
				end
				lzpr_pkg::CFG_ZONE_OFFSET: begin
					cfg_q.zone_offset <= cfg_data[lzpr_pkg::ZOFF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/lzpr_div.sv @@
// ---------------------------------------------------------------------------
// lzpr_div
// Restoring divider, one quotient bit per cycle, shared by the test and rainbow setups.
// ---------------------------------------------------------------------------
module lzpr_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lzpr_pkg::DIVD_W-1:0]     dividend,
	input  logic [lzpr_pkg::DIVR_W-1:0]     divisor,
	output logic                            done,
	output logic [lzpr_pkg::DIVD_W-1:0]     quot,
	output logic [lzpr_pkg::DIVR_W-1:0]     rem
);

	localparam int DW = lzpr_pkg::DIVD_W;
	localparam int RW = lzpr_pkg::DIVR_W;

	logic [DW-1:0]                  quo_q;
	logic [RW-1:0]                  rem_q;
	logic [RW-1:0]                  dsr_q;
	logic [lzpr_pkg::DIVC_W-1:0]    cnt_q;
	logic                           done_q;
	logic [RW:0]                    shifted;
	logic [RW+1:0]                  diff;

	// Trial subtraction of the divisor from the shifted remainder
	always_comb begin
		shifted = {rem_q, quo_q[DW-1]};
		diff    = {1'b0, shifted} - {2'b00, dsr_q};
	end

	// Control: iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= lzpr_pkg::DIVC_W'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == lzpr_pkg::DIVC_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Data: load operands, then shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (diff[RW+1]) begin
				rem_q <= shifted[RW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end else begin
				rem_q <= diff[RW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

@@ rtl/lzpr_dp.sv @@
// ---------------------------------------------------------------------------
// lzpr_dp
// Datapath: frame setup operands and results, pixel color and output register.
// ---------------------------------------------------------------------------
module lzpr_dp #(
	parameter int MAX_PIXELS = lzpr_pkg::MAX_PIXELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lzpr_pkg::cfg_t                  cfg,
	input  lzpr_pkg::cmd_t                  cmd,
	input  logic [lzpr_pkg::TIME_W-1:0]     time_ms,
	input  logic                            dim_on,
	input  logic                            out_ready,
	output lzpr_pkg::sts_t                  sts,
	output logic                            out_valid,
	output logic [lzpr_pkg::IDX_W-1:0]      pixel_index,
	output logic [lzpr_pkg::COL_W-1:0]      red,
	output logic [lzpr_pkg::COL_W-1:0]      green,
	output logic [lzpr_pkg::COL_W-1:0]      blue,
	output logic                            last_pixel
);

	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int S_W   = CNT_W + 2;
	localparam int PW    = lzpr_pkg::PHASE_W;
	localparam int CW    = lzpr_pkg::COL_W;
	localparam int DW    = lzpr_pkg::DIVD_W;
	localparam int RW    = lzpr_pkg::DIVR_W;

	logic [lzpr_pkg::TIME_W-1:0]    t_q;
	logic                           dim_q;
	logic [S_W-1:0]                 s_q;
	logic [PW-1:0]                  phase_q;
	logic [lzpr_pkg::STEP_W-1:0]    step_q;
	logic [CNT_W-1:0]               i_q;
	logic [CW-1:0]                  raw_r_q, raw_g_q, raw_b_q;
	logic                           out_valid_q;
	logic [lzpr_pkg::IDX_W-1:0]     out_idx_q;
	logic [CW-1:0]                  out_r_q, out_g_q, out_b_q;
	logic                           out_last_q;

	logic [CNT_W-1:0]               n_w;
	logic [lzpr_pkg::MS_W-1:0]      per_w, tstep_w;
	logic [DW-1:0]                  div_dividend;
	logic [RW-1:0]                  div_divisor;
	logic                           div_done;
	logic [DW-1:0]                  div_quot;
	logic [RW-1:0]                  div_rem;
	logic [lzpr_pkg::LVL_W:0]       lvl_n, lvl_d;
	logic [lzpr_pkg::BK_W-1:0]      bk;
	logic [PW-1:0]                  ph_g, ph_b;
	logic                           last_w;
	logic                           out_free;

	// Zone length saturated to the supported size, zero periods counted as one
	always_comb begin
		n_w = (cfg.zone_pixels > lzpr_pkg::ZPIX_W'(MAX_PIXELS)) ?
			CNT_W'(MAX_PIXELS) : CNT_W'(cfg.zone_pixels);
		per_w   = (cfg.rainbow_period_ms == '0) ? lzpr_pkg::MS_W'(1) : cfg.rainbow_period_ms;
		tstep_w = (cfg.test_step_ms == '0) ? lzpr_pkg::MS_W'(1) : cfg.test_step_ms;
	end

	// Select divider operands for the requested job
	always_comb begin
		case (cmd.div_op)
			lzpr_pkg::OP_TEST_STEP: begin
				div_dividend = t_q;
				div_divisor  = RW'(tstep_w);
			end
			lzpr_pkg::OP_TEST_MOD: begin
				div_dividend = div_quot;
				div_divisor  = RW'({n_w, 2'b00});
			end
			lzpr_pkg::OP_RB_MOD: begin
				div_dividend = t_q;
				div_divisor  = RW'(per_w);
			end
			lzpr_pkg::OP_RB_PHASE: begin
				// (2 * m * 768 + d) / (2 * d)
				div_dividend = DW'({div_rem[lzpr_pkg::MS_W-1:0], 10'b0})
					+ DW'({div_rem[lzpr_pkg::MS_W-1:0], 9'b0}) + DW'(per_w);
				div_divisor  = RW'({per_w, 1'b0});
			end
			lzpr_pkg::OP_RB_STEP: begin
				div_dividend = DW'(lzpr_pkg::STEP_NUM);
				div_divisor  = RW'(n_w);
			end
			default: begin
				div_dividend = t_q;
				div_divisor  = RW'(1);
			end
		endcase
	end

	lzpr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Brightness as a shift count k for the factor 2^k - 1
	always_comb begin
		lvl_n = ((lzpr_pkg::LVL_W + 1)'(cfg.level) >= (lzpr_pkg::LVL_W + 1)'(lzpr_pkg::LEVELS)) ?
			(lzpr_pkg::LVL_W + 1)'(lzpr_pkg::LEVELS - 1) : (lzpr_pkg::LVL_W + 1)'(cfg.level);
		lvl_d = ((lzpr_pkg::LVL_W + 1)'(cfg.dimmed_level) >=
			(lzpr_pkg::LVL_W + 1)'(lzpr_pkg::LEVELS)) ?
			(lzpr_pkg::LVL_W + 1)'(lzpr_pkg::LEVELS - 1) :
			(lzpr_pkg::LVL_W + 1)'(cfg.dimmed_level);
		if (dim_q && cfg.dimmed_level == '0)
			bk = '0;
		else if (dim_q)
			bk = lzpr_pkg::BK_W'(lvl_d) + lzpr_pkg::BK_W'(9 - lzpr_pkg::LEVELS);
		else
			bk = lzpr_pkg::BK_W'(lvl_n) + lzpr_pkg::BK_W'(9 - lzpr_pkg::LEVELS);
	end

	// Green and blue wheel positions, last-pixel flag and output free flag
	always_comb begin
		ph_g = lzpr_pkg::mod_wheel((PW + 1)'(phase_q) + (PW + 1)'(256));
		ph_b = lzpr_pkg::mod_wheel((PW + 1)'(phase_q) + (PW + 1)'(512));
		last_w = ((CNT_W + 1)'(i_q) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(n_w);
		out_free = !out_valid_q || out_ready;
	end

	// Frame setup registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			t_q   <= time_ms;
			dim_q <= dim_on;
		end
		if (cmd.cap_test)
			s_q <= div_rem[S_W-1:0];
		if (cmd.cap_step)
			step_q <= (div_quot[lzpr_pkg::STEP_W-1:0] == '0) ?
				lzpr_pkg::STEP_W'(1) : div_quot[lzpr_pkg::STEP_W-1:0];
		// Hold phase; load it at setup, advance it per rainbow pixel
		if (cmd.cap_phase)
			phase_q <= (div_quot[PW:0] == (PW + 1)'(lzpr_pkg::PHASE_STEPS)) ?
				'0 : div_quot[PW-1:0];
		else if (cmd.init_pix && cfg.pattern_mode == lzpr_pkg::MODE_CONST)
			phase_q <= cfg.base_phase;
		else if (cmd.pix_emit && cfg.pattern_mode == lzpr_pkg::MODE_RAINBOW)
			phase_q <= lzpr_pkg::mod_wheel((PW + 1)'(phase_q) + (PW + 1)'(step_q));
		// Pixel counter
		if (cmd.init_pix)
			i_q <= '0;
		else if (cmd.pix_emit)
			i_q <= i_q + 1'b1;
	end

	// Unscaled color of the current pixel
	always_ff @(posedge clk) begin
		if (cmd.pix_raw) begin
			case (cfg.pattern_mode)
				lzpr_pkg::MODE_TEST: begin
					raw_r_q <= (i_q == s_q[S_W-1:2] && s_q[1:0] == 2'd0) ? 8'hFF : '0;
					raw_g_q <= (i_q == s_q[S_W-1:2] && s_q[1:0] == 2'd1) ? 8'hFF : '0;
					raw_b_q <= (i_q == s_q[S_W-1:2] && s_q[1:0] == 2'd2) ? 8'hFF : '0;
				end
				lzpr_pkg::MODE_CONST, lzpr_pkg::MODE_RAINBOW: begin
					raw_r_q <= lzpr_pkg::wheel_ch(phase_q);
					raw_g_q <= lzpr_pkg::wheel_ch(ph_g);
					raw_b_q <= lzpr_pkg::wheel_ch(ph_b);
				end
				default: begin
					raw_r_q <= '0;
					raw_g_q <= '0;
					raw_b_q <= '0;
				end
			endcase
		end
	end

	// Output register: hold until taken, load scaled pixel on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pix_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_emit) begin
			out_idx_q  <= lzpr_pkg::IDX_W'(cfg.zone_offset) + lzpr_pkg::IDX_W'(i_q);
			out_r_q    <= lzpr_pkg::scale_ch(raw_r_q, bk);
			out_g_q    <= lzpr_pkg::scale_ch(raw_g_q, bk);
			out_b_q    <= lzpr_pkg::scale_ch(raw_b_q, bk);
			out_last_q <= last_w;
		end
	end

	assign sts.n_zero   = (n_w == '0);
	assign sts.div_done = div_done;
	assign sts.last_pix = last_w;
	assign sts.out_free = out_free;

	assign out_valid   = out_valid_q;
	assign pixel_index = out_idx_q;
	assign red         = out_r_q;
	assign green       = out_g_q;
	assign blue        = out_b_q;
	assign last_pixel  = out_last_q;

endmodule

@@ rtl/lzpr_ctrl.sv @@
// ---------------------------------------------------------------------------
// lzpr_ctrl
// Frame sequencer: runs the setup divisions per pattern, then walks the pixels.
// ---------------------------------------------------------------------------
module lzpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  lzpr_pkg::mode_t   mode,
	input  lzpr_pkg::sts_t    sts,
	output lzpr_pkg::cmd_t    cmd,
	output logic              in_ready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TS_GO,
		ST_TS_RUN,
		ST_TM_GO,
		ST_TM_RUN,
		ST_RM_GO,
		ST_RM_RUN,
		ST_RP_GO,
		ST_RP_RUN,
		ST_RS_GO,
		ST_RS_RUN,
		ST_INIT,
		ST_RAW,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign accept = in_valid && ready_q;

	// State and ready register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && !sts.n_zero) begin
						ready_q <= 1'b0;
						case (mode)
							lzpr_pkg::MODE_TEST:    state_q <= ST_TS_GO;
							lzpr_pkg::MODE_RAINBOW: state_q <= ST_RM_GO;
							default:                state_q <= ST_INIT;
						endcase
					end
				end
				ST_TS_GO:  state_q <= ST_TS_RUN;
				ST_TS_RUN: if (sts.div_done) state_q <= ST_TM_GO;
				ST_TM_GO:  state_q <= ST_TM_RUN;
				ST_TM_RUN: if (sts.div_done) state_q <= ST_INIT;
				ST_RM_GO:  state_q <= ST_RM_RUN;
				ST_RM_RUN: if (sts.div_done) state_q <= ST_RP_GO;
				ST_RP_GO:  state_q <= ST_RP_RUN;
				ST_RP_RUN: if (sts.div_done) state_q <= ST_RS_GO;
				ST_RS_GO:  state_q <= ST_RS_RUN;
				ST_RS_RUN: if (sts.div_done) state_q <= ST_INIT;
				ST_INIT:   state_q <= ST_RAW;
				ST_RAW:    state_q <= ST_EMIT;
				ST_EMIT: begin
					if (sts.out_free) begin
						if (sts.last_pix) begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end else begin
							state_q <= ST_RAW;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	// Decode commands from the current state
	always_comb begin
		cmd           = '0;
		cmd.div_op    = lzpr_pkg::OP_TEST_STEP;
		cmd.latch_in  = (state_q == ST_IDLE) && accept;
		case (state_q)
			ST_TS_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = lzpr_pkg::OP_TEST_STEP;
			end
			ST_TM_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = lzpr_pkg::OP_TEST_MOD;
			end
			ST_TM_RUN: cmd.cap_test = sts.div_done;
			ST_RM_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = lzpr_pkg::OP_RB_MOD;
			end
			ST_RP_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = lzpr_pkg::OP_RB_PHASE;
			end
			ST_RP_RUN: cmd.cap_phase = sts.div_done;
			ST_RS_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = lzpr_pkg::OP_RB_STEP;
			end
			ST_RS_RUN: cmd.cap_step = sts.div_done;
			ST_INIT:   cmd.init_pix = 1'b1;
			ST_RAW:    cmd.pix_raw  = 1'b1;
			ST_EMIT:   cmd.pix_emit = sts.out_free;
			default: begin
			end
		endcase
	end

	assign in_ready = ready_q;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED zone pattern renderer. Frame tick requests
// go in on the slave stream and pixel requests come back on the master stream.
// A local model of the four patterns computes the pixels of every accepted
// tick. The checker compares each returned pixel with the oldest pending one.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 300;
	localparam int HOLD_CYCLES    = 800;

	typedef struct packed {
		logic [lzpr_pkg::IDX_W-1:0] index;
		logic [lzpr_pkg::COL_W-1:0] red;
		logic [lzpr_pkg::COL_W-1:0] green;
		logic [lzpr_pkg::COL_W-1:0] blue;
		logic                       last;
	} pixel_t;

	logic                             clk           = 1'b0;
	logic                             arst_n        = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	// [31:0] time_ms, [32] dim_on
	logic [lzpr_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	// [6:0] pixel_index, [14:7] red, [22:15] green, [30:23] blue
	logic [lzpr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             m_axis_tlast;
	logic                             cfg_we        = 1'b0;
	lzpr_pkg::cfg_idx_t               cfg_index     = lzpr_pkg::CFG_PATTERN_MODE;
	logic [lzpr_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

	lzpr_pkg::cfg_t zone_regs;
	pixel_t         pixels_due[$];
	int             errors       = 0;
	int             quiet_cycles = 0;
	int             hold_left    = 0;
	bit             hold_request = 1'b0;
	bit             steady       = 1'b0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	led_zone_pattern_renderer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Triangular wheel: rise over the first third, fall over the second, then off
	function automatic int wheel_level(input int p);
		if (p <= 255)
			return p;
		if (p <= 511)
			return 511 - p;
		return 0;
	endfunction

	function automatic logic [lzpr_pkg::COL_W-1:0] scale_channel(input int c,
		input int bright);
		return lzpr_pkg::COL_W'((c * bright) / 255);
	endfunction

	// Dimmed level zero blanks the frame; levels are 3 bits so never exceed the top
	function automatic int frame_brightness(input logic dim);
		int lvl;
		lvl = zone_regs.level;
		if (dim) begin
			if (zone_regs.dimmed_level == 0)
				return 0;
			lvl = zone_regs.dimmed_level;
		end
		return 8'hFF >> (lzpr_pkg::LEVELS - 1 - lvl);
	endfunction

	// Queue the pixels that one frame tick produces under the current registers
	function automatic void predict_frame(input logic [lzpr_pkg::TIME_W-1:0] t,
		input logic dim);
		int     n, bright, active, s, phase0, stride, p, cr, cg, cb;
		longint tm, span;
		pixel_t px;
		n = zone_regs.zone_pixels;
		if (n > lzpr_pkg::MAX_PIXELS_DEF)
			n = lzpr_pkg::MAX_PIXELS_DEF;
		if (n == 0)
			return;
		bright = frame_brightness(dim);
		tm     = {32'd0, t};
		active = -1;
		s      = 0;
		phase0 = 0;
		stride = 1;
		if (zone_regs.pattern_mode == lzpr_pkg::MODE_TEST) begin
			span   = (zone_regs.test_step_ms == 0) ? 1 : zone_regs.test_step_ms;
			s      = int'((tm / span) % (4 * n));
			active = s / 4;
		end else if (zone_regs.pattern_mode == lzpr_pkg::MODE_RAINBOW) begin
			span   = (zone_regs.rainbow_period_ms == 0) ? 1 : zone_regs.rainbow_period_ms;
			tm     = tm % span;
			// round half up
			phase0 = int'(((2 * tm * lzpr_pkg::PHASE_STEPS + span) / (2 * span))
				% lzpr_pkg::PHASE_STEPS);
			stride = (lzpr_pkg::PHASE_STEPS / n) / 3;
			if (stride == 0)
				stride = 1;
		end
		for (int i = 0; i < n; i++) begin
			cr = 0;
			cg = 0;
			cb = 0;
			if (zone_regs.pattern_mode == lzpr_pkg::MODE_CONST ||
				zone_regs.pattern_mode == lzpr_pkg::MODE_RAINBOW) begin
				p = (zone_regs.pattern_mode == lzpr_pkg::MODE_CONST) ?
					int'(zone_regs.base_phase) :
					(phase0 + i * stride) % lzpr_pkg::PHASE_STEPS;
				cr = wheel_level(p);
				cg = wheel_level((p + 256) % lzpr_pkg::PHASE_STEPS);
				cb = wheel_level((p + 512) % lzpr_pkg::PHASE_STEPS);
			end else if (zone_regs.pattern_mode == lzpr_pkg::MODE_TEST && i == active) begin
				cr = (s % 4 == 0) ? 255 : 0;
				cg = (s % 4 == 1) ? 255 : 0;
				cb = (s % 4 == 2) ? 255 : 0;
			end
			px.index = lzpr_pkg::IDX_W'(zone_regs.zone_offset + i);
			px.red   = scale_channel(cr, bright);
			px.green = scale_channel(cg, bright);
			px.blue  = scale_channel(cb, bright);
			px.last  = (i == n - 1);
			pixels_due.push_back(px);
		end
	endfunction

	function automatic lzpr_pkg::cfg_t regs_with(input lzpr_pkg::mode_t mode,
		input int phase, input int lvl, input int dimmed, input int period,
		input int step_ms, input int pixels, input int offset);
		lzpr_pkg::cfg_t r;
		r.pattern_mode      = mode;
		r.base_phase        = lzpr_pkg::PHASE_W'(phase);
		r.level             = lzpr_pkg::LVL_W'(lvl);
		r.dimmed_level      = lzpr_pkg::LVL_W'(dimmed);
		r.rainbow_period_ms = lzpr_pkg::MS_W'(period);
		r.test_step_ms      = lzpr_pkg::MS_W'(step_ms);
		r.zone_pixels       = lzpr_pkg::ZPIX_W'(pixels);
		r.zone_offset       = lzpr_pkg::ZOFF_W'(offset);
		return r;
	endfunction

	// Offer one frame tick and hold it until accepted
	task automatic send_tick(input logic [lzpr_pkg::TIME_W-1:0] t, input logic dim);
		while (!steady && $urandom_range(99) < 13) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, dim, t};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_frame(t, dim);
		@(negedge clk);
	endtask

	// Drop the request, wait for every pending pixel, then let the block go quiet
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pixels_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input lzpr_pkg::cfg_idx_t idx,
		input logic [lzpr_pkg::CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
	endtask

	// Program every register while the block is idle
	task automatic load_regs(input lzpr_pkg::cfg_t regs);
		settle();
		write_reg(lzpr_pkg::CFG_PATTERN_MODE, lzpr_pkg::CFG_DATA_W'(regs.pattern_mode));
		write_reg(lzpr_pkg::CFG_BASE_PHASE,   lzpr_pkg::CFG_DATA_W'(regs.base_phase));
		write_reg(lzpr_pkg::CFG_LEVEL,        lzpr_pkg::CFG_DATA_W'(regs.level));
		write_reg(lzpr_pkg::CFG_DIMMED_LEVEL, lzpr_pkg::CFG_DATA_W'(regs.dimmed_level));
		write_reg(lzpr_pkg::CFG_RAINBOW_MS,
			lzpr_pkg::CFG_DATA_W'(regs.rainbow_period_ms));
		write_reg(lzpr_pkg::CFG_TEST_STEP_MS, lzpr_pkg::CFG_DATA_W'(regs.test_step_ms));
		write_reg(lzpr_pkg::CFG_ZONE_PIXELS,  lzpr_pkg::CFG_DATA_W'(regs.zone_pixels));
		write_reg(lzpr_pkg::CFG_ZONE_OFFSET,  lzpr_pkg::CFG_DATA_W'(regs.zone_offset));
		cfg_we    <= 1'b0;
		zone_regs = regs;
	endtask

	// Receiver: random stalls except while steady, and a long hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (steady) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= 13);
		end
	end

	// Compare each returned pixel with the oldest pending one
	always @(posedge clk) begin
		pixel_t seen;
		pixel_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.index = m_axis_tdata[6:0];
			seen.red   = m_axis_tdata[14:7];
			seen.green = m_axis_tdata[22:15];
			seen.blue  = m_axis_tdata[30:23];
			seen.last  = m_axis_tlast;
			if (pixels_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected pixel idx=%0d rgb=%02h%02h%02h last=%0b",
					$time, seen.index, seen.red, seen.green, seen.blue, seen.last);
			end else begin
				want = pixels_due.pop_front();
				if (want.index !== seen.index || want.red !== seen.red ||
					want.green !== seen.green || want.blue !== seen.blue ||
					want.last !== seen.last) begin
					errors++;
					$display("%0t: pixel mismatch expected idx=%0d rgb=%02h%02h%02h last=%0b, %s",
						$time, want.index, want.red, want.green, want.blue, want.last,
						$sformatf("actual idx=%0d rgb=%02h%02h%02h last=%0b",
						seen.index, seen.red, seen.green, seen.blue, seen.last));
				end
			end
		end
	end

	// Watchdog on cycles without any accepted request
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Registers as they come out of reset: six-pixel rainbow
	task automatic test_reset_defaults();
		send_tick(32'd2500, 1'b0);
		send_tick(32'hFFFF_FFFF, 1'b1);
	endtask

	// Dark frame at the widest zone and the highest offset
	task automatic test_dark_pattern();
		load_regs(regs_with(lzpr_pkg::MODE_DARK, 767, 7, 7, 1000, 1, 64, 63));
		send_tick(32'd0, 1'b0);
	endtask

	// Walk red, green, blue, black; zero step counts as one; oversize zone saturates
	task automatic test_test_pattern();
		int unsigned walk[5] = '{0, 1, 2, 3, 15};
		load_regs(regs_with(lzpr_pkg::MODE_TEST, 0, 7, 0, 5000, 0, 4, 5));
		foreach (walk[k])
			send_tick(walk[k], 1'b0);
		load_regs(regs_with(lzpr_pkg::MODE_TEST, 0, 3, 0, 5000, 65535, 127, 0));
		send_tick(32'hFFFF_FFFF, 1'b1);
		send_tick(32'd65535 * 5, 1'b0);
	endtask

	// Constant color at the wheel corners and past the end of the wheel
	task automatic test_constant_pattern();
		int unsigned phases[5] = '{0, 255, 511, 767, 1023};
		int unsigned lvls[5]   = '{0, 7, 3, 7, 5};
		int unsigned dimmed[5] = '{7, 0, 1, 7, 7};
		bit          dims[5]   = '{0, 1, 1, 1, 0};
		foreach (phases[k]) begin
			load_regs(regs_with(lzpr_pkg::MODE_CONST, phases[k], lvls[k], dimmed[k],
				5000, 500, 8, k));
			send_tick($urandom, dims[k]);
		end
	endtask

	// Zero period, longest period, empty zone and a half-step phase rounding up
	task automatic test_rainbow_pattern();
		load_regs(regs_with(lzpr_pkg::MODE_RAINBOW, 0, 7, 1, 0, 500, 1, 0));
		send_tick(32'd12345, 1'b0);
		load_regs(regs_with(lzpr_pkg::MODE_RAINBOW, 0, 7, 1, 65535, 500, 127, 0));
		send_tick(32'hFFFF_FFFF, 1'b0);
		load_regs(regs_with(lzpr_pkg::MODE_RAINBOW, 0, 7, 1, 5000, 500, 0, 9));
		send_tick(32'd7, 1'b1);
		load_regs(regs_with(lzpr_pkg::MODE_RAINBOW, 0, 6, 1, 1536, 500, 3, 62));
		send_tick(32'd1, 1'b0);
	endtask

	// Hold off the receiver while ticks keep coming so the input stalls
	task automatic test_backpressure();
		load_regs(regs_with(lzpr_pkg::MODE_RAINBOW, 100, 7, 1, 3000, 500, 64, 0));
		steady       = 1'b1;
		hold_request = 1'b1;
		repeat (12)
			send_tick($urandom, 1'(($urandom_range(1))));
		settle();
		steady = 1'b0;
	endtask

	// Random register sets, each followed by a burst of random ticks
	task automatic test_random_frames();
		lzpr_pkg::cfg_t regs;
		int             pick;
		logic [31:0]    t;
		for (int ph = 0; ph < 8; ph++) begin
			regs.pattern_mode = lzpr_pkg::mode_t'($urandom_range(3));
			regs.base_phase   = lzpr_pkg::PHASE_W'($urandom_range(1023));
			regs.level        = lzpr_pkg::LVL_W'($urandom_range(7));
			regs.dimmed_level = lzpr_pkg::LVL_W'($urandom_range(7));
			pick = $urandom_range(3);
			regs.rainbow_period_ms = (pick == 0) ? lzpr_pkg::MS_W'(0) :
				(pick == 1) ? lzpr_pkg::MS_W'(16'hFFFF) :
				lzpr_pkg::MS_W'($urandom_range(1, 20000));
			pick = $urandom_range(3);
			regs.test_step_ms = (pick == 0) ? lzpr_pkg::MS_W'(0) :
				(pick == 1) ? lzpr_pkg::MS_W'(16'hFFFF) :
				lzpr_pkg::MS_W'($urandom_range(1, 200));
			pick = $urandom_range(9);
			regs.zone_pixels = (pick == 0) ? lzpr_pkg::ZPIX_W'(0) :
				(pick == 1) ? lzpr_pkg::ZPIX_W'($urandom_range(65, 127)) :
				(pick == 2) ? lzpr_pkg::ZPIX_W'(64) :
				lzpr_pkg::ZPIX_W'($urandom_range(1, 64));
			regs.zone_offset = lzpr_pkg::ZOFF_W'($urandom_range(63));
			load_regs(regs);
			steady = (ph == 3);
			repeat (16) begin
				t = $urandom_range(1) ? $urandom : $urandom_range(20000);
				send_tick(t, 1'($urandom_range(1)));
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		zone_regs = regs_with(lzpr_pkg::MODE_RAINBOW, 0, 7, 1, 5000, 500, 6, 0);
		repeat (9)
			@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_dark_pattern();
		test_test_pattern();
		test_constant_pattern();
		test_rainbow_pattern();
		test_backpressure();
		test_random_frames();
		settle();
		if (errors == 0 && pixels_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
